FILE: rtl/tkse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tkse_pkg: shared types and constants of the terminal key sequence encoder
// Field widths, byte codes, the named-key table and the descriptor that
// travels from the front end to the back end.
// ----------------------------------------------------------------------------
package tkse_pkg;

   // field widths
   localparam int KEY_W      = 21;
   localparam int MOD_W      = 4;
   localparam int BYTE_W     = 8;
   localparam int REQ_DATA_W = 32;
   localparam int MAX_BYTES  = 7;
   localparam int CNT_W      = 3;
   localparam int SEQ_W      = MAX_BYTES * BYTE_W;

   // named keys
   localparam int ROW_COUNT = 26;
   localparam logic [KEY_W-1:0] NAMED_BASE_DEF = 21'h110000;
   localparam logic [KEY_W-1:0] CODE_MAX       = 21'h10FFFF;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // byte codes
   localparam logic [BYTE_W-1:0] CH_ESC   = 8'h1B;
   localparam logic [BYTE_W-1:0] CH_DEL   = 8'h7F;
   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CH_O     = 8'h4F;
   localparam logic [BYTE_W-1:0] CH_LBRK  = 8'h5B;
   localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;
   localparam logic [BYTE_W-1:0] CH_TILDE = 8'h7E;
   localparam logic [BYTE_W-1:0] CH_AT    = 8'h40;
   localparam logic [BYTE_W-1:0] CH_QUEST = 8'h3F;
   localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

   // one row of the named-key table
   typedef struct packed {
      logic [BYTE_W-1:0] fin;   // final byte, zero for single-byte keys
      logic [4:0]        par;   // tilde parameter, zero for letter keys
      logic              ss3;   // unmodified form is ESC O fin
   } row_type;

   // encoded sequence handed to the back end
   typedef struct packed {
      logic [CNT_W-1:0]                count;  // bytes, 1..7
      logic [MAX_BYTES-1:0][BYTE_W-1:0] seq;   // byte 0 goes out first
   } desc_type;

   // queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   function automatic row_type row_lookup(input logic [4:0] idx);
      row_type r;
      r = '0;
      unique case (idx)
         5'd4:  r = '{fin: CH_TILDE, par: 5'd3,  ss3: 1'b0};
         5'd5:  r = '{fin: CH_TILDE, par: 5'd2,  ss3: 1'b0};
         5'd6:  r = '{fin: 8'h41,    par: 5'd0,  ss3: 1'b0};
         5'd7:  r = '{fin: 8'h42,    par: 5'd0,  ss3: 1'b0};
         5'd8:  r = '{fin: 8'h44,    par: 5'd0,  ss3: 1'b0};
         5'd9:  r = '{fin: 8'h43,    par: 5'd0,  ss3: 1'b0};
         5'd10: r = '{fin: 8'h48,    par: 5'd0,  ss3: 1'b0};
         5'd11: r = '{fin: 8'h46,    par: 5'd0,  ss3: 1'b0};
         5'd12: r = '{fin: CH_TILDE, par: 5'd5,  ss3: 1'b0};
         5'd13: r = '{fin: CH_TILDE, par: 5'd6,  ss3: 1'b0};
         5'd14: r = '{fin: 8'h50,    par: 5'd0,  ss3: 1'b1};
         5'd15: r = '{fin: 8'h51,    par: 5'd0,  ss3: 1'b1};
         5'd16: r = '{fin: 8'h52,    par: 5'd0,  ss3: 1'b1};
         5'd17: r = '{fin: 8'h53,    par: 5'd0,  ss3: 1'b1};
         5'd18: r = '{fin: CH_TILDE, par: 5'd15, ss3: 1'b0};
         5'd19: r = '{fin: CH_TILDE, par: 5'd17, ss3: 1'b0};
         5'd20: r = '{fin: CH_TILDE, par: 5'd18, ss3: 1'b0};
         5'd21: r = '{fin: CH_TILDE, par: 5'd19, ss3: 1'b0};
         5'd22: r = '{fin: CH_TILDE, par: 5'd20, ss3: 1'b0};
         5'd23: r = '{fin: CH_TILDE, par: 5'd21, ss3: 1'b0};
         5'd24: r = '{fin: CH_TILDE, par: 5'd23, ss3: 1'b0};
         5'd25: r = '{fin: CH_TILDE, par: 5'd24, ss3: 1'b0};
         default: r = '0;   // Enter, Backspace, Tab, Escape and unused rows
      endcase
      return r;
   endfunction

   // byte of the four single-byte named keys
   function automatic logic [BYTE_W-1:0] single_byte(input logic [1:0] idx);
      logic [BYTE_W-1:0] b;
      unique case (idx)
         2'd0:    b = CH_CR;
         2'd1:    b = CH_DEL;
         2'd2:    b = CH_TAB;
         default: b = CH_ESC;
      endcase
      return b;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/terminal_key_sequence_encoder_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Path: a key goes through the queue, the serializer and the output register.
// Throughput: one byte per cycle while rsp_tready is high and keys are queued;
//   a key sends 1..7 bytes, and the serializer loads the next key as the
//   current one hands over its final byte. Keys that send nothing are dropped.
// Reset: synchronous; clears queue pointers, serializer and output valid.
// ----------------------------------------------------------------------------
// terminal_key_sequence_encoder_top: terminal key sequence encoder
// Encodes key events into terminal byte sequences: front encoder, descriptor
// queue and byte serializer.
// ----------------------------------------------------------------------------
module terminal_key_sequence_encoder_top #(
   parameter logic [tkse_pkg::KEY_W-1:0] NAMED_BASE = tkse_pkg::NAMED_BASE_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   input  wire  [tkse_pkg::REQ_DATA_W-1:0]  req_tdata,   // key_code, modifiers
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [tkse_pkg::BYTE_W-1:0]      rsp_tdata,   // out_byte
   output logic                             rsp_tlast    // last_byte
);
   import tkse_pkg::*;

   qstat_type qstat;
   desc_type  push_desc;
   desc_type  pop_desc;
   logic      push;
   logic      pop;

   tkse_front #(
      .NAMED_BASE (NAMED_BASE)
   ) u_front (
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .qstat      (qstat),
      .push       (push),
      .push_desc  (push_desc)
   );

   tkse_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .pop_desc  (pop_desc),
      .qstat     (qstat)
   );

   tkse_back u_back (
      .clock      (clock),
      .reset      (reset),
      .qstat      (qstat),
      .pop_desc   (pop_desc),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // queue never written when full
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !qstat.full) else $error("queue push while full");

   // queue never read when empty
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !qstat.empty) else $error("queue pop while empty");

   // full and empty are exclusive
   a_qstat: assert property (@(posedge clock) disable iff (reset)
      !(qstat.full && qstat.empty)) else $error("queue full and empty");

   // nothing is offered right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid) else $error("output valid after reset");

endmodule
`default_nettype wire

FILE: rtl/tkse_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tkse_front: key event classifier and encoder
// Accepts one key event, builds its whole byte sequence and pushes it
// into the queue; events that send nothing are dropped here.
// ----------------------------------------------------------------------------
module tkse_front #(
   parameter logic [tkse_pkg::KEY_W-1:0] NAMED_BASE = tkse_pkg::NAMED_BASE_DEF
) (
   input  wire                                reset,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   input  wire  [tkse_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  tkse_pkg::qstat_type                qstat,
   output logic                               push,
   output tkse_pkg::desc_type                 push_desc
);
   import tkse_pkg::*;

   logic [KEY_W-1:0]  key_code;
   logic [MOD_W-1:0]  mods;
   logic [BYTE_W-1:0] seq_b [8];
   logic [3:0]        n;
   logic              esc_pre;
   logic [KEY_W-1:0]  row_idx;
   row_type           row;
   logic [4:0]        mod_v;
   logic [4:0]        par_v;
   logic              ctrl_ok;
   logic [BYTE_W-1:0] ctrl_b;
   logic              keep;

   function automatic logic [BYTE_W-1:0] dec_tens(input logic [4:0] v);
      return (v >= 5'd20) ? (CH_ZERO + 8'd2) : (CH_ZERO + 8'd1);
   endfunction

   function automatic logic [BYTE_W-1:0] dec_ones(input logic [4:0] v);
      logic [4:0] r;
      r = (v >= 5'd20) ? (v - 5'd20) : ((v >= 5'd10) ? (v - 5'd10) : v);
      return CH_ZERO + {3'b000, r};
   endfunction

   assign key_code = req_tdata[KEY_W-1:0];
   assign mods     = req_tdata[KEY_W+MOD_W-1:KEY_W];
   assign esc_pre  = mods[1] | mods[3];
   assign row_idx  = key_code - NAMED_BASE;
   assign row      = row_lookup(row_idx[4:0]);
   assign mod_v    = {1'b0, mods} + 5'd1;
   assign par_v    = (row.par != 5'd0) ? row.par : 5'd1;

   // control-column byte
   always_comb begin
      ctrl_ok = 1'b1;
      ctrl_b  = '0;
      if (key_code >= 21'h61 && key_code <= 21'h7A) begin
         ctrl_b = key_code[7:0] - 8'h60;
      end else if (key_code >= 21'h41 && key_code <= 21'h5A) begin
         ctrl_b = key_code[7:0] - CH_AT;
      end else if (key_code == {13'd0, CH_SPACE} || key_code == {13'd0, CH_AT}) begin
         ctrl_b = '0;
      end else if (key_code >= 21'h5B && key_code <= 21'h5F) begin
         ctrl_b = key_code[7:0] - CH_AT;
      end else if (key_code == {13'd0, CH_QUEST}) begin
         ctrl_b = CH_DEL;
      end else begin
         ctrl_ok = 1'b0;
      end
   end

   // build the sequence byte by byte
   always_comb begin
      seq_b = '{default: '0};
      n     = '0;
      if (key_code >= NAMED_BASE) begin
         if (row_idx < KEY_W'(ROW_COUNT)) begin
            if (row.fin == '0) begin
               if (esc_pre) begin
                  seq_b[n[2:0]] = CH_ESC; n = n + 4'd1;
               end
               seq_b[n[2:0]] = single_byte(row_idx[1:0]); n = n + 4'd1;
            end else begin
               seq_b[n[2:0]] = CH_ESC; n = n + 4'd1;
               if (mod_v == 5'd1 && row.ss3) begin
                  seq_b[n[2:0]] = CH_O;    n = n + 4'd1;
                  seq_b[n[2:0]] = row.fin; n = n + 4'd1;
               end else begin
                  seq_b[n[2:0]] = CH_LBRK; n = n + 4'd1;
                  if (row.par != 5'd0 || mod_v != 5'd1) begin
                     if (par_v >= 5'd10) begin
                        seq_b[n[2:0]] = dec_tens(par_v); n = n + 4'd1;
                     end
                     seq_b[n[2:0]] = dec_ones(par_v); n = n + 4'd1;
                  end
                  if (mod_v != 5'd1) begin
                     seq_b[n[2:0]] = CH_SEMI; n = n + 4'd1;
                     if (mod_v >= 5'd10) begin
                        seq_b[n[2:0]] = dec_tens(mod_v); n = n + 4'd1;
                     end
                     seq_b[n[2:0]] = dec_ones(mod_v); n = n + 4'd1;
                  end
                  seq_b[n[2:0]] = row.fin; n = n + 4'd1;
               end
            end
         end
      end else if (key_code <= CODE_MAX) begin
         if (mods[2]) begin
            // unmapped ctrl key sends nothing, not even the prefix
            if (ctrl_ok) begin
               if (esc_pre) begin
                  seq_b[n[2:0]] = CH_ESC; n = n + 4'd1;
               end
               seq_b[n[2:0]] = ctrl_b; n = n + 4'd1;
            end
         end else begin
            if (esc_pre) begin
               seq_b[n[2:0]] = CH_ESC; n = n + 4'd1;
            end
            if (key_code < 21'h80) begin
               seq_b[n[2:0]] = key_code[7:0]; n = n + 4'd1;
            end else if (key_code < 21'h800) begin
               seq_b[n[2:0]] = {3'b110, key_code[10:6]}; n = n + 4'd1;
               seq_b[n[2:0]] = {2'b10, key_code[5:0]};   n = n + 4'd1;
            end else if (key_code < 21'h10000) begin
               seq_b[n[2:0]] = {4'b1110, key_code[15:12]}; n = n + 4'd1;
               seq_b[n[2:0]] = {2'b10, key_code[11:6]};    n = n + 4'd1;
               seq_b[n[2:0]] = {2'b10, key_code[5:0]};     n = n + 4'd1;
            end else begin
               seq_b[n[2:0]] = {5'b11110, key_code[20:18]}; n = n + 4'd1;
               seq_b[n[2:0]] = {2'b10, key_code[17:12]};    n = n + 4'd1;
               seq_b[n[2:0]] = {2'b10, key_code[11:6]};     n = n + 4'd1;
               seq_b[n[2:0]] = {2'b10, key_code[5:0]};      n = n + 4'd1;
            end
         end
      end
   end

   // an empty or overlong sequence is dropped
   assign keep = (n != 4'd0) && (n <= 4'(MAX_BYTES));

   always_comb begin
      push_desc.count = n[CNT_W-1:0];
      for (int k = 0; k < MAX_BYTES; k++) begin
         push_desc.seq[k] = seq_b[k];
      end
   end

   assign req_tready = ~qstat.full & ~reset;
   assign push       = req_tvalid & req_tready & keep;

endmodule
`default_nettype wire

FILE: rtl/tkse_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tkse_queue: descriptor queue
// Short FIFO of encoded sequences between the front and back ends.
// ----------------------------------------------------------------------------
module tkse_queue (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push,
   input  tkse_pkg::desc_type    push_desc,
   input  wire                   pop,
   output tkse_pkg::desc_type    pop_desc,
   output tkse_pkg::qstat_type   qstat
);
   import tkse_pkg::*;

   localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   desc_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign qstat.full  = (fill_ff == FILL_W'(QUEUE_DEPTH));
   assign qstat.empty = (fill_ff == '0);
   assign pop_desc    = entry_ff[rd_ptr_ff];

   // pointer and fill update
   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/tkse_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tkse_back: byte serializer
// Takes one sequence from the queue and sends it a byte per cycle, while
// rsp_tready does not stall it, through an output register, marking the final byte.
// ----------------------------------------------------------------------------
module tkse_back (
   input  wire                           clock,
   input  wire                           reset,
   input  tkse_pkg::qstat_type           qstat,
   input  tkse_pkg::desc_type            pop_desc,
   output logic                          pop,
   output logic                          rsp_tvalid,
   input  wire                           rsp_tready,
   output logic [tkse_pkg::BYTE_W-1:0]   rsp_tdata,   // out_byte
   output logic                          rsp_tlast    // last_byte
);
   import tkse_pkg::*;

   logic                 busy_ff, busy_in;
   logic [SEQ_W-1:0]     seq_ff, seq_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]    out_byte_ff, out_byte_in;
   logic                 out_last_ff, out_last_in;
   logic                 load_out;
   logic                 take;
   logic                 final_b;

   assign load_out = ~out_valid_ff | rsp_tready;
   assign take     = load_out & busy_ff;
   assign final_b  = (cnt_ff == CNT_W'(1));
   // refill when idle, or as the current sequence hands over its final byte
   assign pop      = ~qstat.empty & (~busy_ff | (take & final_b));

   always_comb begin
      busy_in      = busy_ff;
      seq_in       = seq_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (load_out) begin
         out_valid_in = busy_ff;
      end
      if (take) begin
         out_byte_in = seq_ff[BYTE_W-1:0];
         out_last_in = final_b;
         seq_in      = {{BYTE_W{1'b0}}, seq_ff[SEQ_W-1:BYTE_W]};
         cnt_in      = cnt_ff - CNT_W'(1);
         if (final_b) begin
            busy_in = 1'b0;
         end
      end
      if (pop) begin
         busy_in = 1'b1;
         seq_in  = pop_desc.seq;
         cnt_in  = pop_desc.count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      seq_ff      <= seq_in;
      cnt_ff      <= cnt_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;

endmodule
`default_nettype wire
